// ===== design/pdd_pkg.sv =====
// Shared types and constants for the PID differential drive controller.
// Used by pdd_cfg, pdd_core and pid_differential_drive.
package pdd_pkg;

  localparam int unsigned PosW   = 13;
  localparam int unsigned ErrW   = 14;
  localparam int unsigned IntW   = 16;
  localparam int unsigned DiffW  = 15;
  localparam int unsigned NumW   = 31;
  localparam int unsigned DivInW = 25;
  localparam int unsigned MagicW = 26;
  localparam int unsigned QuotW  = 16;
  localparam int unsigned SpdW   = 19;
  localparam int unsigned AddrW  = 5;

  // floor(n / 625) == (n * DivMagic) >> DivShift for n < 2**25; 10000 = 16 * 625
  localparam logic [MagicW-1:0] DivMagic = 26'd54975582;
  localparam int unsigned       DivShift = 35;

  typedef enum logic [2:0] {
    REG_KP     = 3'd0,
    REG_KI     = 3'd1,
    REG_KD     = 3'd2,
    REG_BASE   = 3'd3,
    REG_MAX    = 3'd4,
    REG_CENTER = 3'd5,
    REG_LIMIT  = 3'd6
  } pdd_reg_e;

  typedef struct packed {
    logic [9:0]  kp_milli;
    logic [8:0]  ki_tenthou;
    logic [9:0]  kd_milli;
    logic [7:0]  base_speed;
    logic [7:0]  max_speed;
    logic [12:0] center_position;
    logic [14:0] integral_limit;
  } pdd_cfg_t;

  typedef struct packed {
    logic [7:0] right_duty;
    logic       right_reverse;
    logic       right_forward;
    logic [7:0] left_duty;
    logic       left_reverse;
    logic       left_forward;
  } pdd_out_t;

endpackage

// ===== design/pid_differential_drive.sv =====
// Line-following PID controller for a two-wheel drive, top level.
// Instantiates pdd_cfg and pdd_core; depends on pdd_pkg.
//
// One position sample is taken per transfer, one every clock cycle when the output side keeps
// up; each sample yields one wheel-drive result through the five pipeline stages (error and
// integral, gain products, sum, divide by 10000, wheel clamp). The integral and the previous
// error update at the input transfer, so consecutive samples chain without bubbles. Output
// stalls propagate back stage by stage; empty stages still take new samples.
// Config writes are meant for when no sample is in flight.
module pid_differential_drive (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [pdd_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  input  logic                      s_tvalid_i,
  output logic                      s_tready_o,
  input  logic [15:0]               s_tdata_i,  // [12:0] line_position, [15:13] zero
  output logic                      m_tvalid_o,
  input  logic                      m_tready_i,
  // [0] left_forward, [1] left_reverse, [9:2] left_duty, [10] right_forward,
  // [11] right_reverse, [19:12] right_duty, [23:20] zero
  output logic [23:0]               m_tdata_o
);
  import pdd_pkg::*;

  pdd_cfg_t cfg;
  pdd_out_t res;

  pdd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pdd_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .pos_i      (s_tdata_i[PosW-1:0]),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .res_o      (res)
  );

  assign m_tdata_o = {4'd0, res};

endmodule

// ===== design/pdd_cfg.sv =====
// Configuration register file with an APB-style write/read port.
// Depends on pdd_pkg for the register index codes and the config struct.
module pdd_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pdd_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output pdd_pkg::pdd_cfg_t          cfg_o
);
  import pdd_pkg::*;

  pdd_cfg_t cfg_q, cfg_d;
  logic     wr_en;
  pdd_reg_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = pdd_reg_e'(paddr[4:2]);
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_KP:     cfg_d.kp_milli        = pwdata[9:0];
        REG_KI:     cfg_d.ki_tenthou      = pwdata[8:0];
        REG_KD:     cfg_d.kd_milli        = pwdata[9:0];
        REG_BASE:   cfg_d.base_speed      = pwdata[7:0];
        REG_MAX:    cfg_d.max_speed       = pwdata[7:0];
        REG_CENTER: cfg_d.center_position = pwdata[12:0];
        REG_LIMIT:  cfg_d.integral_limit  = pwdata[14:0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_KP:     prdata = {22'd0, cfg_q.kp_milli};
      REG_KI:     prdata = {23'd0, cfg_q.ki_tenthou};
      REG_KD:     prdata = {22'd0, cfg_q.kd_milli};
      REG_BASE:   prdata = {24'd0, cfg_q.base_speed};
      REG_MAX:    prdata = {24'd0, cfg_q.max_speed};
      REG_CENTER: prdata = {19'd0, cfg_q.center_position};
      REG_LIMIT:  prdata = {17'd0, cfg_q.integral_limit};
      default:    prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kp_milli        <= 10'd100;
      cfg_q.ki_tenthou      <= 9'd10;
      cfg_q.kd_milli        <= 10'd500;
      cfg_q.base_speed      <= 8'd150;
      cfg_q.max_speed       <= 8'd200;
      cfg_q.center_position <= 13'd3500;
      cfg_q.integral_limit  <= 15'd1000;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== design/pdd_core.sv =====
// Five-stage PID pipeline: error and integral, gain products, sum, divide, wheel drive.
// Depends on pdd_pkg for widths, the divide constant and the config/result structs.
module pdd_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  pdd_pkg::pdd_cfg_t         cfg_i,
  input  logic                      s_tvalid_i,
  output logic                      s_tready_o,
  input  logic [pdd_pkg::PosW-1:0]  pos_i,
  output logic                      m_tvalid_o,
  input  logic                      m_tready_i,
  output pdd_pkg::pdd_out_t         res_o
);
  import pdd_pkg::*;

  // stage valids and advance enables
  logic v1_q, v2_q, v3_q, v4_q, vo_q;
  logic adv1, adv2, adv3, adv4, advo, acc;

  // loop state
  logic signed [IntW-1:0] integ_q, integ_d;
  logic signed [ErrW-1:0] prev_q;

  // stage 1
  logic signed [ErrW-1:0]  err_d, err_q;
  logic signed [DiffW-1:0] diff_d, diff_q;
  logic signed [IntW-1:0]  int1_q;
  logic signed [IntW:0]    isum, ilim;

  // stage 2
  logic signed [28:0] pp_d, pp_q;
  logic signed [29:0] pd_d, pd_q;
  logic signed [25:0] pi_d, pi_q;
  logic signed [28:0] kp10, err_x;
  logic signed [29:0] kd10, diff_x;
  logic signed [25:0] ki_x, int_x;

  // stage 3
  logic signed [NumW-1:0]  num;
  logic [NumW-1:0]         mag;
  logic [DivInW-1:0]       m16_q;
  logic                    neg3_q;

  // stage 4
  logic [DivInW+MagicW-1:0] qprod;
  logic [QuotW-1:0]         quo_q;
  logic                     neg4_q;

  // output stage
  logic signed [SpdW-1:0] corr, base_s, lim_s, rspd, lspd, rclp, lclp;
  pdd_out_t               res_d, res_q;

  assign advo = !vo_q || m_tready_i;
  assign adv4 = !v4_q || advo;
  assign adv3 = !v3_q || adv4;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;
  assign s_tready_o = adv1;
  assign acc  = s_tvalid_i && adv1;
  assign m_tvalid_o = vo_q;
  assign res_o = res_q;

  // error, derivative term and clamped integral
  always_comb begin
    err_d  = $signed({1'b0, pos_i}) - $signed({1'b0, cfg_i.center_position});
    diff_d = DiffW'(err_d) - DiffW'(prev_q);
    isum   = (IntW+1)'(integ_q) + (IntW+1)'(err_d);
    ilim   = $signed({2'b00, cfg_i.integral_limit});
    if (isum > ilim) begin
      integ_d = IntW'(ilim);
    end else if (isum < -ilim) begin
      integ_d = IntW'(-ilim);
    end else begin
      integ_d = IntW'(isum);
    end
  end

  // gain products over the common denominator
  always_comb begin
    kp10   = $signed({19'd0, cfg_i.kp_milli}) * 29'sd10;
    kd10   = $signed({20'd0, cfg_i.kd_milli}) * 30'sd10;
    ki_x   = $signed({17'd0, cfg_i.ki_tenthou});
    err_x  = 29'(err_q);
    diff_x = 30'(diff_q);
    int_x  = 26'(int1_q);
    pp_d   = kp10 * err_x;
    pd_d   = kd10 * diff_x;
    pi_d   = ki_x * int_x;
  end

  always_comb begin
    num   = NumW'(pp_q) + NumW'(pd_q) + NumW'(pi_q);
    mag   = num[NumW-1] ? NumW'(-num) : NumW'(num);
    qprod = (DivInW+MagicW)'(m16_q) * (DivInW+MagicW)'(DivMagic);
  end

  // apply correction, clamp and split into direction and duty
  always_comb begin
    corr   = neg4_q ? -$signed({3'b000, quo_q}) : $signed({3'b000, quo_q});
    base_s = $signed({11'd0, cfg_i.base_speed});
    lim_s  = $signed({11'd0, cfg_i.max_speed});
    rspd   = base_s + corr;
    lspd   = base_s - corr;
    rclp   = (rspd > lim_s) ? lim_s : ((rspd < -lim_s) ? -lim_s : rspd);
    lclp   = (lspd > lim_s) ? lim_s : ((lspd < -lim_s) ? -lim_s : lspd);
    res_d.right_forward = (rclp > 0);
    res_d.right_reverse = rclp[SpdW-1];
    res_d.right_duty    = rclp[SpdW-1] ? 8'(-rclp) : 8'(rclp);
    res_d.left_forward  = (lclp > 0);
    res_d.left_reverse  = lclp[SpdW-1];
    res_d.left_duty     = lclp[SpdW-1] ? 8'(-lclp) : 8'(lclp);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      vo_q    <= 1'b0;
      integ_q <= '0;
      prev_q  <= '0;
    end else begin
      if (adv1) v1_q <= s_tvalid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
      if (adv4) v4_q <= v3_q;
      if (advo) vo_q <= v4_q;
      if (acc) begin
        integ_q <= integ_d;
        prev_q  <= err_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      err_q  <= err_d;
      diff_q <= diff_d;
      int1_q <= integ_d;
    end
    if (adv2 && v1_q) begin
      pp_q <= pp_d;
      pd_q <= pd_d;
      pi_q <= pi_d;
    end
    if (adv3 && v2_q) begin
      m16_q  <= mag[DivInW+3:4];
      neg3_q <= num[NumW-1];
    end
    if (adv4 && v3_q) begin
      quo_q  <= qprod[DivShift+QuotW-1:DivShift];
      neg4_q <= neg3_q;
    end
    if (advo && v4_q) begin
      res_q <= res_d;
    end
  end

  a_left_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vo_q |-> !(res_q.left_forward && res_q.left_reverse))
    else $error("left wheel driven both ways");

  a_zero_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vo_q |-> ((res_q.right_duty == 8'd0) == (!res_q.right_forward && !res_q.right_reverse)))
    else $error("right duty disagrees with direction flags");

  a_max_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vo_q |-> (res_q.left_duty <= cfg_i.max_speed && res_q.right_duty <= cfg_i.max_speed))
    else $error("duty above max speed");

  a_prev_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> (prev_q == $past(err_d)))
    else $error("previous error not updated on transfer");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Stream-level testbench for pid_differential_drive: APB register writes, random idling and
// stalling, and a cycle-free model of the PID steering law. Depends on pdd_pkg and the RTL.
module tb_top;
  import pdd_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned UnmappedReg   = 7;
  localparam int unsigned PhaseItems    = 140;

  logic             clk_i    = 1'b0;
  logic             rst_ni   = 1'b0;
  logic             psel     = 1'b0;
  logic             penable  = 1'b0;
  logic             pwrite   = 1'b0;
  logic [AddrW-1:0] paddr    = '0;
  logic [31:0]      pwdata   = '0;
  logic [31:0]      prdata;
  logic             pready;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [15:0]      s_tdata  = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [23:0]      m_tdata;

  pdd_cfg_t         gains;
  longint           integ_acc;
  longint           last_err;
  logic [PosW-1:0]  pending_pos_q[$];
  pdd_out_t         expected_drive_q[$];
  pdd_out_t         want_drive;
  pdd_out_t         got_drive;
  int unsigned      send_idle_pct  = 0;
  int unsigned      recv_stall_pct = 0;
  int unsigned      mismatches     = 0;
  int unsigned      quiet_cycles   = 0;

  pid_differential_drive i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .s_tvalid_i(s_tvalid),
    .s_tready_o(s_tready),
    .s_tdata_i (s_tdata),
    .m_tvalid_o(m_tvalid),
    .m_tready_i(m_tready),
    .m_tdata_o (m_tdata)
  );

  always #5 clk_i = ~clk_i;

  function automatic longint saturate(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // {duty, reverse, forward}
  function automatic logic [9:0] wheel(input longint speed);
    longint mag;
    mag = (speed < 0) ? -speed : speed;
    return {mag[7:0], speed < 0, speed > 0};
  endfunction

  function automatic pdd_out_t steer(input logic [PosW-1:0] pos);
    longint err;
    longint num;
    longint corr;
    longint lim;
    longint base;
    err = longint'(pos) - longint'(gains.center_position);
    integ_acc = saturate(integ_acc + err, longint'(gains.integral_limit));
    num = 10 * longint'(gains.kp_milli) * err
        + longint'(gains.ki_tenthou) * integ_acc
        + 10 * longint'(gains.kd_milli) * (err - last_err);
    corr = num / 10000;
    last_err = err;
    lim = longint'(gains.max_speed);
    base = longint'(gains.base_speed);
    return pdd_out_t'({wheel(saturate(base + corr, lim)), wheel(saturate(base - corr, lim))});
  endfunction

  task automatic apb_write(input int unsigned idx, input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'(idx * 4);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_KP:     gains.kp_milli        = value[9:0];
      REG_KI:     gains.ki_tenthou      = value[8:0];
      REG_KD:     gains.kd_milli        = value[9:0];
      REG_BASE:   gains.base_speed      = value[7:0];
      REG_MAX:    gains.max_speed       = value[7:0];
      REG_CENTER: gains.center_position = value[12:0];
      REG_LIMIT:  gains.integral_limit  = value[14:0];
      default: ;
    endcase
  endtask

  task automatic set_gains(input logic [31:0] kp, input logic [31:0] ki, input logic [31:0] kd,
                           input logic [31:0] base, input logic [31:0] top,
                           input logic [31:0] center, input logic [31:0] limit);
    apb_write(REG_KP, kp);
    apb_write(REG_KI, ki);
    apb_write(REG_KD, kd);
    apb_write(REG_BASE, base);
    apb_write(REG_MAX, top);
    apb_write(REG_CENTER, center);
    apb_write(REG_LIMIT, limit);
    apb_write(UnmappedReg, $urandom());
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_field(input int unsigned width);
    logic [31:0] ones;
    logic [31:0] v;
    int unsigned r;
    ones = (32'd1 << width) - 32'd1;
    r = $urandom_range(9);
    if (r == 0) v = '0;
    else if (r == 1) v = ones;
    else v = $urandom() & ones;
    if ($urandom_range(1) == 1) v = v | (32'($urandom()) << width);
    return v;
  endfunction

  function automatic logic [PosW-1:0] near_center(input int offset);
    int v;
    v = int'(gains.center_position) + offset;
    if (v < 0) v = 0;
    if (v > 8191) v = 8191;
    return PosW'(v);
  endfunction

  task automatic push_random(input int unsigned count);
    int unsigned n;
    int unsigned r;
    int unsigned run;
    int side;
    n = 0;
    while (n < count) begin
      r = $urandom_range(99);
      if (r < 10) begin
        // one-sided run to wind the integral into its clamp
        side = ($urandom_range(1) == 1) ? 1 : -1;
        run = $urandom_range(4, 20);
        repeat (run) begin
          pending_pos_q.push_back(near_center(side * int'($urandom_range(50, 3000))));
          n++;
        end
      end else if (r < 60) begin
        pending_pos_q.push_back(near_center(int'($urandom_range(0, 1200)) - 600));
        n++;
      end else if (r < 85) begin
        pending_pos_q.push_back(PosW'($urandom_range(0, 8191)));
        n++;
      end else begin
        pending_pos_q.push_back(PosW'($urandom_range(0, 7000)));
        n++;
      end
    end
  endtask

  task automatic drain;
    @(negedge clk_i);
    while (pending_pos_q.size() != 0 || s_tvalid || expected_drive_q.size() != 0)
      @(negedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
    end else begin
      if (s_tvalid && s_tready) expected_drive_q.push_back(steer(s_tdata[PosW-1:0]));
      if (!s_tvalid || s_tready) begin
        if (pending_pos_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata  <= {3'b000, pending_pos_q.pop_front()};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got_drive = pdd_out_t'(m_tdata[19:0]);
        if (expected_drive_q.size() == 0) begin
          $display("%0t: unexpected drive transfer %h", $time, m_tdata);
          mismatches++;
        end else begin
          want_drive = expected_drive_q.pop_front();
          if (m_tdata !== {4'b0000, want_drive}) begin
            $display("%0t: drive expected L f%b r%b d%0d R f%b r%b d%0d (%h), got L f%b r%b d%0d R f%b r%b d%0d (%h)",
                     $time, want_drive.left_forward, want_drive.left_reverse,
                     want_drive.left_duty, want_drive.right_forward, want_drive.right_reverse,
                     want_drive.right_duty, {4'b0000, want_drive},
                     got_drive.left_forward, got_drive.left_reverse, got_drive.left_duty,
                     got_drive.right_forward, got_drive.right_reverse, got_drive.right_duty,
                     m_tdata);
            mismatches++;
          end
        end
      end
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("pid_differential_drive: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    gains.kp_milli        = 10'd100;
    gains.ki_tenthou      = 9'd10;
    gains.kd_milli        = 10'd500;
    gains.base_speed      = 8'd150;
    gains.max_speed       = 8'd200;
    gains.center_position = 13'd3500;
    gains.integral_limit  = 15'd1000;
    integ_acc = 0;
    last_err  = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset gains: extremes, centered line, integral wound to both clamps
    foreach (pending_pos_q[i]) ;
    pending_pos_q = '{13'd3500, 13'd0, 13'd8191, 13'd7000, 13'd0, 13'd0, 13'd0,
                      13'd8191, 13'd8191, 13'd3500, 13'd1, 13'd4096};
    drain();

    // all-ones writes: every register at its top value
    set_gains('1, '1, '1, '1, '1, '1, '1);
    pending_pos_q = '{13'd0, 13'd8191, 13'd8191, 13'd0, 13'd5461};
    drain();

    // integral held at zero, zero base: centered line gives a stopped wheel
    set_gains(300, 200, 400, 0, 100, 3500, 0);
    pending_pos_q = '{13'd3500, 13'd3500, 13'd7000, 13'd0, 13'd3500, 13'd3500};
    drain();

    // zero max speed stops both wheels
    set_gains(1000, 500, 1000, 255, 0, 7000, 32767);
    pending_pos_q = '{13'd0, 13'd7000, 13'd8191};
    drain();

    for (int unsigned phase = 0; phase < 12; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct <= 65; recv_stall_pct <= 0;  end
        2: begin send_idle_pct <= 0;  recv_stall_pct <= 65; end
        default: begin send_idle_pct <= 28; recv_stall_pct <= 28; end
      endcase
      set_gains(pick_field(10), pick_field(9), pick_field(10), pick_field(8), pick_field(8),
                pick_field(13),
                ($urandom_range(1) == 1) ? 32'($urandom_range(0, 3000)) : pick_field(15));
      push_random(PhaseItems);
      drain();
    end

    if (mismatches == 0 && expected_drive_q.size() == 0) begin
      $display("pid_differential_drive: match");
    end else begin
      $display("pid_differential_drive: mismatch");
    end
    $finish;
  end

endmodule

// ===== pid_differential_drive.f =====
design/pdd_pkg.sv
design/pdd_cfg.sv
design/pdd_core.sv
design/pid_differential_drive.sv
bench/tb_top.sv
